/* hw/rtl/crpe_pkg.sv */
// Shared types and constants for the Catmull-Rom point evaluator.
package crpe_pkg;

    // Curve parameter and scale widths are fixed by the field formats.
    localparam int T_W     = 16;   // t, unsigned Q0.16
    localparam int SCALE_W = 16;   // scale, unsigned Q8.8
    localparam int FRAC_T  = 16;

    // Doubled basis weights fit in 21 signed bits (magnitude below 2^20).
    localparam int WGT_W = 21;

    typedef logic signed [WGT_W-1:0] wgt_t;

    localparam wgt_t WGT_TWO = 21'sd131072;   // 2.0 in signed Q4.16

    // Blend rounding: add one half of 2^17, then drop 17 bits.
    localparam int BLEND_SHIFT = 17;
    localparam int BLEND_BIAS  = 65536;

    // Scale rounding: add one half of 2^8, then drop 8 bits.
    localparam int SCALE_SHIFT = 8;
    localparam int SCALE_BIAS  = 128;

    // Pipeline stage numbers, input side first.
    localparam int PIPE_STAGES = 7;
    localparam int STG_T2      = 0;
    localparam int STG_T3      = 1;
    localparam int STG_WGT     = 2;
    localparam int STG_PROD    = 3;
    localparam int STG_SUM     = 4;
    localparam int STG_SPROD   = 5;
    localparam int STG_SOUT    = 6;

    // One load strobe per pipeline stage.
    typedef struct packed {
        logic [PIPE_STAGES-1:0] load;
    } pipe_ctl_t;

endpackage

/* hw/rtl/crpe_weight_gen.sv */
// Three-stage generator of the doubled Catmull-Rom basis weights from t.
module crpe_weight_gen (
    input  logic                       clk,
    input  crpe_pkg::pipe_ctl_t        ctl,
    input  logic [crpe_pkg::T_W-1:0]   curve_param,
    output crpe_pkg::wgt_t             wgt [4]
);
    import crpe_pkg::*;

    logic [T_W-1:0]   t_a_reg, t_b_reg;
    logic [T_W-1:0]   t2_a_reg, t2_b_reg, t3_b_reg;
    logic [2*T_W-1:0] tt_prod, ttt_prod;
    wgt_t             t_s, t2_s, t3_s;
    wgt_t             wgt_next [4];
    wgt_t             wgt_reg  [4];

    assign tt_prod  = (2*T_W)'(curve_param) * (2*T_W)'(curve_param);
    assign ttt_prod = (2*T_W)'(t2_a_reg) * (2*T_W)'(t_a_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_T2])
        begin
            t_a_reg  <= curve_param;
            t2_a_reg <= tt_prod[2*T_W-1:FRAC_T];
        end
        if (ctl.load[STG_T3])
        begin
            t_b_reg  <= t_a_reg;
            t2_b_reg <= t2_a_reg;
            t3_b_reg <= ttt_prod[2*T_W-1:FRAC_T];
        end
        if (ctl.load[STG_WGT])
        begin
            for (int k = 0; k < 4; k++)
            begin
                wgt_reg[k] <= wgt_next[k];
            end
        end
    end

    always_comb
    begin
        t_s  = $signed({{(WGT_W-T_W){1'b0}}, t_b_reg});
        t2_s = $signed({{(WGT_W-T_W){1'b0}}, t2_b_reg});
        t3_s = $signed({{(WGT_W-T_W){1'b0}}, t3_b_reg});
        wgt_next[0] = -t3_s + (t2_s <<< 1) - t_s;
        wgt_next[1] = (t3_s <<< 1) + t3_s - (t2_s <<< 2) - t2_s + WGT_TWO;
        wgt_next[2] = -(t3_s <<< 1) - t3_s + (t2_s <<< 2) + t_s;
        wgt_next[3] = t3_s - t2_s;
    end

    assign wgt = wgt_reg;

endmodule

/* hw/rtl/crpe_blend.sv */
// Two-stage weighted blend of four control coordinates with rounding and saturation.
module crpe_blend #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              clk,
    input  crpe_pkg::pipe_ctl_t               ctl,
    input  crpe_pkg::wgt_t                    wgt [4],
    input  logic signed [COORD_WIDTH-1:0]     pt  [4],
    output logic signed [COORD_WIDTH+1:0]     blended
);
    import crpe_pkg::*;

    localparam int OW = COORD_WIDTH + 2;
    localparam int PW = WGT_W + COORD_WIDTH;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-OW+1){1'b1}}, {(OW-1){1'b0}}};

    logic signed [PW-1:0] prod_reg [4];
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] shifted;
    logic signed [OW-1:0] blended_next, blended_reg;

    always_comb
    begin
        acc = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]) + SW'(prod_reg[3])
            + SW'(BLEND_BIAS);
        shifted = acc >>> BLEND_SHIFT;
        priority if (shifted > SAT_HI)
            blended_next = SAT_HI[OW-1:0];
        else if (shifted < SAT_LO)
            blended_next = SAT_LO[OW-1:0];
        else
            blended_next = shifted[OW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_PROD])
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= PW'(wgt[k]) * PW'(pt[k]);
            end
        end
        if (ctl.load[STG_SUM])
        begin
            blended_reg <= blended_next;
        end
    end

    assign blended = blended_reg;

endmodule

/* hw/rtl/crpe_scaler.sv */
// Two-stage saturating multiply of a coordinate by the Q8.8 scale.
module crpe_scaler #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                clk,
    input  crpe_pkg::pipe_ctl_t                 ctl,
    input  logic signed [COORD_WIDTH+1:0]       coord,
    input  logic [crpe_pkg::SCALE_W-1:0]        scale,
    output logic signed [COORD_WIDTH+9:0]       scaled
);
    import crpe_pkg::*;

    localparam int IW = COORD_WIDTH + 2;
    localparam int OW = COORD_WIDTH + 10;
    localparam int PW = IW + SCALE_W + 1;
    localparam int RW = PW + 1;
    localparam logic signed [RW-1:0] SAT_HI = {{(RW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO = {{(RW-OW+1){1'b1}}, {(OW-1){1'b0}}};

    logic signed [PW-1:0] prod_reg;
    logic signed [RW-1:0] rounded;
    logic signed [OW-1:0] scaled_next, scaled_reg;

    always_comb
    begin
        rounded = (RW'(prod_reg) + RW'(SCALE_BIAS)) >>> SCALE_SHIFT;
        priority if (rounded > SAT_HI)
            scaled_next = SAT_HI[OW-1:0];
        else if (rounded < SAT_LO)
            scaled_next = SAT_LO[OW-1:0];
        else
            scaled_next = rounded[OW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_SPROD])
        begin
            prod_reg <= PW'(coord) * PW'($signed({1'b0, scale}));
        end
        if (ctl.load[STG_SOUT])
        begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule

/* hw/rtl/catmull_rom_point_eval.sv */
// Top level of the pipelined uniform Catmull-Rom point evaluator.
//
//  channel     dir  handshake                 contents
//  s_axis      in   s_tvalid / s_tready       t, four control points (x, z), height
//  m_axis      out  m_tvalid / m_tready       point, height, scaled point
//  config      in   cfg_wr_en                 scale factor, Q8.8
//
// Seven register stages: t^2, t^3, basis weights, weighted products, sum and
// round, scale product, scale round and saturate. One transfer can be accepted
// every cycle while the output is not stalled.
// Reset clears the stage valid bits and loads the scale factor with 1.0.
// Each stage holds when its successor is full and stalled, so bubbles close
// up behind a stalled output and input stays open while any stage is empty.
module catmull_rom_point_eval #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // s_tdata, low bit up: curve_param[16], pt0_x, pt0_z, pt1_x, pt1_z,
    // pt2_x, pt2_z, pt3_x, pt3_z, height_in (COORD_WIDTH each), zero pad
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [((16+9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // m_tdata, low bit up: out_x[COORD_WIDTH+2], out_z[COORD_WIDTH+2],
    // out_height[COORD_WIDTH], scaled_x[COORD_WIDTH+10], scaled_z[COORD_WIDTH+10],
    // zero pad
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [((24+5*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic                       cfg_wr_en,
    input  logic [crpe_pkg::SCALE_W-1:0] cfg_wr_data
);
    import crpe_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int OUT_DW = ((24 + 5*CW + 7) / 8) * 8;
    localparam int PT_LO  = T_W;
    localparam int HT_LO  = T_W + 8*CW;

    // Handshake and stage control.
    logic [PIPE_STAGES-1:0] valid_reg, valid_next, ready;
    pipe_ctl_t              ctl;

    logic [SCALE_W-1:0]     scale_reg, scale_next;

    logic signed [CW-1:0]   pts_in  [8];
    logic signed [CW-1:0]   pts_a_reg [8];
    logic signed [CW-1:0]   pts_b_reg [8];
    logic signed [CW-1:0]   pts_c_reg [8];
    logic signed [CW-1:0]   pts_x [4];
    logic signed [CW-1:0]   pts_z [4];
    logic signed [CW-1:0]   height_reg [PIPE_STAGES];

    wgt_t                   wgt [4];
    logic signed [CW+1:0]   blend_x, blend_z;
    logic signed [CW+9:0]   scaled_x, scaled_z;

    // A stage may load when it is empty or its content moves on this cycle.
    always_comb
    begin
        ready[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || m_tready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        valid_next[0] = ready[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
        ctl.load = ready;
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[PIPE_STAGES-1];

    assign scale_next = cfg_wr_en ? cfg_wr_data : scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            scale_reg <= SCALE_W'(256);
        end
        else
        begin
            valid_reg <= valid_next;
            scale_reg <= scale_next;
        end
    end

    // Unpack the control points in field order.
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            pts_in[j] = $signed(s_tdata[PT_LO + j*CW +: CW]);
        end
        for (int k = 0; k < 4; k++)
        begin
            pts_x[k] = pts_c_reg[2*k];
            pts_z[k] = pts_c_reg[2*k+1];
        end
    end

    // Carry the points alongside the weight stages and the height through all.
    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_T2])
        begin
            pts_a_reg <= pts_in;
        end
        if (ctl.load[STG_T3])
        begin
            pts_b_reg <= pts_a_reg;
        end
        if (ctl.load[STG_WGT])
        begin
            pts_c_reg <= pts_b_reg;
        end
        if (ctl.load[0])
        begin
            height_reg[0] <= $signed(s_tdata[HT_LO +: CW]);
        end
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            if (ctl.load[i])
            begin
                height_reg[i] <= height_reg[i-1];
            end
        end
    end

    crpe_weight_gen u_weight_gen (
        .clk         (clk),
        .ctl         (ctl),
        .curve_param (s_tdata[T_W-1:0]),
        .wgt         (wgt)
    );

    crpe_blend #(.COORD_WIDTH(CW)) u_blend_x (
        .clk     (clk),
        .ctl     (ctl),
        .wgt     (wgt),
        .pt      (pts_x),
        .blended (blend_x)
    );

    crpe_blend #(.COORD_WIDTH(CW)) u_blend_z (
        .clk     (clk),
        .ctl     (ctl),
        .wgt     (wgt),
        .pt      (pts_z),
        .blended (blend_z)
    );

    // Hold the unscaled point next to the scaler so both leave together.
    logic signed [CW+1:0] blend_x_d_reg, blend_z_d_reg;
    logic signed [CW+1:0] blend_x_q_reg, blend_z_q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[STG_SPROD])
        begin
            blend_x_d_reg <= blend_x;
            blend_z_d_reg <= blend_z;
        end
        if (ctl.load[STG_SOUT])
        begin
            blend_x_q_reg <= blend_x_d_reg;
            blend_z_q_reg <= blend_z_d_reg;
        end
    end

    crpe_scaler #(.COORD_WIDTH(CW)) u_scaler_x (
        .clk    (clk),
        .ctl    (ctl),
        .coord  (blend_x),
        .scale  (scale_reg),
        .scaled (scaled_x)
    );

    crpe_scaler #(.COORD_WIDTH(CW)) u_scaler_z (
        .clk    (clk),
        .ctl    (ctl),
        .coord  (blend_z),
        .scale  (scale_reg),
        .scaled (scaled_z)
    );

    // Pack the result, first field lowest, zero pad on top.
    assign m_tdata = OUT_DW'({scaled_z, scaled_x, height_reg[PIPE_STAGES-1],
                              blend_z_q_reg, blend_x_q_reg});

endmodule
